// ===== sv/ble_frame_checker_crc16_top_defines.svh =====
// assertion macros for the frame checker top level
// no dependencies; taken in by `include from the top level
`ifndef BLE_FRAME_CHECKER_CRC16_TOP_DEFINES_SVH
`define BLE_FRAME_CHECKER_CRC16_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");

// next-cycle implication, disabled during reset
`define BFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");

`endif

// ===== sv/bfc_pkg.sv =====
// shared types and constants for the frame checker
// no dependencies
package bfc_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 512;
   localparam int unsigned HDR_BYTES       = 12;
   localparam int unsigned CRC_BYTES       = 2;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   // queue depth must be a power of two (pointers wrap by overflow)
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SHORT    = 3'd1,
      STATUS_LEN_FAIL = 3'd2,
      STATUS_CRC_FAIL = 3'd3,
      STATUS_OVERSIZE = 3'd4
   } status_type;

   // one classified byte, handed from front to back
   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        last_byte;
      logic        seq_shift;
      logic        cmd_shift;
      logic        fdw_shift;
      logic        crc_update;
      logic        is_data;
      logic        crc_hi;
      logic        crc_lo;
      logic        oversize;
      logic        short_frame;
      logic        len_fail;
      logic [15:0] header_length;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/ble_frame_checker_crc16_top.sv =====
// top level of the plaintext frame checker with crc-16/modbus
// depends on bfc_pkg, bfc_front, bfc_queue, bfc_back and the defines header
//
//   channel   dir  transfer when         payload
//   req_      in   req_valid & !stall   frame_byte, last_byte
//   rsp_      out  rsp_valid & !stall   result_kind, payload_byte, frame_status,
//                                       seq_number, command_code, data_length,
//                                       peer_length
//
// one byte per cycle sustained while rsp_stall stays low; a data byte or last byte gives a result on rsp_
// through the queue write and then crc/capture into the result register (a pop waits for a free slot)
// the rate is set by the byte-wide crc update, done combinationally in the back end
// reset is synchronous; it clears position, queue pointers and result valid
// req_stall rises only when the four-entry queue is full
// a stalled result holds and the back end stops popping, so the queue fills up
`include "ble_frame_checker_crc16_top_defines.svh"

module ble_frame_checker_crc16_top (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_frame_status,
   output logic [31:0] rsp_seq_number,
   output logic [15:0] rsp_command_code,
   output logic [15:0] rsp_data_length,
   output logic [15:0] rsp_peer_length
);

   bfc_pkg::entry_type        front_entry;
   bfc_pkg::entry_type        head_entry;
   bfc_pkg::queue_status_type queue_status;
   logic                      req_xfer;
   logic                      pop;

   // a valid input byte transfers whenever the queue has room
   assign req_stall = queue_status.full;
   assign req_xfer  = req_valid && !req_stall;

   // front: tracks byte position and header length, tags each byte
   bfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_xfer),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .entry      (front_entry)
   );

   // decoupling queue, lets input and output stall on their own
   bfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_xfer),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // back: crc, header fields, recorded seq/peer length, result register
   bfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .queue_status     (queue_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_command_code (rsp_command_code),
      .rsp_data_length  (rsp_data_length),
      .rsp_peer_length  (rsp_peer_length)
   );

   // payload transfers carry nothing in the report fields
   `BFC_ASSERT_NOW(a_payload_clean, clock, reset,
      rsp_valid && rsp_result_kind == bfc_pkg::KIND_PAYLOAD,
      rsp_frame_status == 3'(bfc_pkg::STATUS_OK) && rsp_seq_number == 32'd0 &&
      rsp_peer_length == 16'd0)

   // oversize or short reports never show header fields
   `BFC_ASSERT_NOW(a_bad_frame_no_header, clock, reset,
      rsp_valid && rsp_result_kind == bfc_pkg::KIND_REPORT &&
      (rsp_frame_status == 3'(bfc_pkg::STATUS_OVERSIZE) ||
       rsp_frame_status == 3'(bfc_pkg::STATUS_SHORT)),
      rsp_command_code == 16'd0 && rsp_data_length == 16'd0)

   // the back end never pops an empty queue
   `BFC_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !queue_status.empty)

   // a pop into a free slot of a data byte or last byte yields a result next cycle
   `BFC_ASSERT_NEXT(a_pop_makes_result, clock, reset,
      pop && (head_entry.last_byte || head_entry.is_data), rsp_valid)

endmodule

// ===== sv/bfc_front.sv =====
// front end: byte position, header length and per-byte classification
// depends on bfc_pkg
module bfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         frame_byte,
   input  logic               last_byte,
   output bfc_pkg::entry_type entry
);

   logic [15:0] pos_ff, pos_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] hlen_ff, hlen_in;

   logic        live;
   logic [16:0] crc_pos;
   logic        in_body;

   always_comb begin
      live    = !ovf_ff;
      crc_pos = {1'b0, hlen_ff} + 17'(bfc_pkg::HDR_BYTES);
      in_body = ({1'b0, pos_ff} < crc_pos) || (pos_ff < 16'(bfc_pkg::HDR_BYTES));

      hlen_in = hlen_ff;
      if (live && (pos_ff == 16'd10 || pos_ff == 16'd11)) begin
         hlen_in = {hlen_ff[7:0], frame_byte};
      end

      entry.frame_byte    = frame_byte;
      entry.last_byte     = last_byte;
      entry.seq_shift     = live && (pos_ff < 16'd4);
      entry.cmd_shift     = live && (pos_ff == 16'd8 || pos_ff == 16'd9);
      entry.fdw_shift     = live && (pos_ff == 16'd12 || pos_ff == 16'd13);
      entry.crc_update    = live && in_body;
      entry.is_data       = live && in_body && (pos_ff >= 16'(bfc_pkg::HDR_BYTES));
      entry.crc_hi        = live && !in_body && ({1'b0, pos_ff} == crc_pos);
      entry.crc_lo        = live && !in_body && ({1'b0, pos_ff} == crc_pos + 17'd1);
      // frame length is pos + 1
      entry.oversize      = ovf_ff || ({1'b0, pos_ff} >= 17'(bfc_pkg::MAX_FRAME_BYTES));
      entry.short_frame   = pos_ff < 16'(bfc_pkg::HDR_BYTES + bfc_pkg::CRC_BYTES - 1);
      entry.len_fail      = ({2'b0, hlen_ff} + 18'(bfc_pkg::HDR_BYTES + bfc_pkg::CRC_BYTES))
                            > ({2'b0, pos_ff} + 18'd1);
      entry.header_length = hlen_in;

      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (last_byte) begin
         pos_in = '0;
         ovf_in = 1'b0;
      end else if (pos_ff == 16'hFFFF) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = pos_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
         hlen_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         ovf_ff  <= ovf_in;
         hlen_ff <= last_byte ? 16'd0 : hlen_in;
      end
   end

endmodule

// ===== sv/bfc_queue.sv =====
// short queue of classified bytes between front and back
// depends on bfc_pkg
module bfc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfc_pkg::entry_type        push_entry,
   input  logic                      pop,
   output bfc_pkg::entry_type        head_entry,
   output bfc_pkg::queue_status_type status
);

   bfc_pkg::entry_type                 mem_ff [bfc_pkg::QUEUE_DEPTH];
   logic [bfc_pkg::QUEUE_AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [bfc_pkg::QUEUE_CW-1:0]       count_ff, count_in;

   always_comb begin
      head_entry   = mem_ff[rd_ptr_ff];
      status.full  = count_ff == bfc_pkg::QUEUE_CW'(bfc_pkg::QUEUE_DEPTH);
      status.empty = count_ff == '0;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/bfc_back.sv =====
// back end: crc, header capture, recorded values and the result register
// depends on bfc_pkg
module bfc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bfc_pkg::entry_type        head_entry,
   input  bfc_pkg::queue_status_type queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_result_kind,
   output logic [7:0]                rsp_payload_byte,
   output logic [2:0]                rsp_frame_status,
   output logic [31:0]               rsp_seq_number,
   output logic [15:0]               rsp_command_code,
   output logic [15:0]               rsp_data_length,
   output logic [15:0]               rsp_peer_length
);

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic [7:0]  d;
      logic        lsb;
      c = crc;
      d = b;
      for (int i = 0; i < 8; i++) begin
         lsb = c[0] ^ d[0];
         c   = c >> 1;
         if (lsb) begin
            c = c ^ bfc_pkg::CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_end_ff, crc_end_in;
   logic [15:0] crc_rx_ff, crc_rx_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [15:0] fdw_ff, fdw_in;
   logic [31:0] kept_seq_ff, kept_seq_in;
   logic [15:0] kept_peer_ff, kept_peer_in;

   logic                out_valid_ff;
   logic                out_kind_ff;
   logic [7:0]          out_byte_ff;
   bfc_pkg::status_type out_status_ff;
   logic [31:0]         out_seq_ff;
   logic [15:0]         out_cmd_ff, out_len_ff, out_peer_ff;

   logic                slot_free;
   logic                emit;
   bfc_pkg::status_type status;
   logic                recorded;
   bfc_pkg::entry_type  e;

   always_comb begin
      e         = head_entry;
      slot_free = !out_valid_ff || !rsp_stall;
      pop       = !queue_status.empty && slot_free;
      emit      = pop && (e.last_byte || e.is_data);

      crc_in     = e.crc_update ? crc_byte(crc_ff, e.frame_byte) : crc_ff;
      crc_end_in = e.crc_hi ? crc_ff : crc_end_ff;
      crc_rx_in  = crc_rx_ff;
      if (e.crc_hi) begin
         crc_rx_in = {e.frame_byte, crc_rx_ff[7:0]};
      end else if (e.crc_lo) begin
         crc_rx_in = {crc_rx_ff[15:8], e.frame_byte};
      end
      seq_in = e.seq_shift ? {seq_ff[23:0], e.frame_byte} : seq_ff;
      cmd_in = e.cmd_shift ? {cmd_ff[7:0], e.frame_byte} : cmd_ff;
      fdw_in = e.fdw_shift ? {fdw_ff[7:0], e.frame_byte} : fdw_ff;

      recorded     = e.last_byte && !e.oversize && !e.short_frame;
      kept_seq_in  = recorded ? seq_in : kept_seq_ff;
      kept_peer_in = kept_peer_ff;
      if (recorded && cmd_in == 16'd0 && e.header_length >= 16'd2) begin
         kept_peer_in = fdw_in;
      end

      priority if (e.oversize) begin
         status = bfc_pkg::STATUS_OVERSIZE;
      end else if (e.short_frame) begin
         status = bfc_pkg::STATUS_SHORT;
      end else if (e.len_fail) begin
         status = bfc_pkg::STATUS_LEN_FAIL;
      end else if (crc_rx_in != crc_end_in) begin
         status = bfc_pkg::STATUS_CRC_FAIL;
      end else begin
         status = bfc_pkg::STATUS_OK;
      end
   end

   // per-frame state and recorded values
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= bfc_pkg::CRC_INIT;
         crc_end_ff   <= '0;
         crc_rx_ff    <= '0;
         seq_ff       <= '0;
         cmd_ff       <= '0;
         fdw_ff       <= '0;
         kept_seq_ff  <= '0;
         kept_peer_ff <= '0;
      end else if (pop) begin
         kept_seq_ff  <= kept_seq_in;
         kept_peer_ff <= kept_peer_in;
         if (e.last_byte) begin
            crc_ff     <= bfc_pkg::CRC_INIT;
            crc_end_ff <= '0;
            crc_rx_ff  <= '0;
            seq_ff     <= '0;
            cmd_ff     <= '0;
            fdw_ff     <= '0;
         end else begin
            crc_ff     <= crc_in;
            crc_end_ff <= crc_end_in;
            crc_rx_ff  <= crc_rx_in;
            seq_ff     <= seq_in;
            cmd_ff     <= cmd_in;
            fdw_ff     <= fdw_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (e.last_byte) begin
            out_kind_ff   <= bfc_pkg::KIND_REPORT;
            out_byte_ff   <= '0;
            out_status_ff <= status;
            out_seq_ff    <= kept_seq_in;
            out_cmd_ff    <= recorded ? cmd_in : 16'd0;
            out_len_ff    <= recorded ? e.header_length : 16'd0;
            out_peer_ff   <= kept_peer_in;
         end else begin
            out_kind_ff   <= bfc_pkg::KIND_PAYLOAD;
            out_byte_ff   <= e.frame_byte;
            out_status_ff <= bfc_pkg::STATUS_OK;
            out_seq_ff    <= '0;
            out_cmd_ff    <= '0;
            out_len_ff    <= '0;
            out_peer_ff   <= '0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_status = 3'(out_status_ff);
   assign rsp_seq_number   = out_seq_ff;
   assign rsp_command_code = out_cmd_ff;
   assign rsp_data_length  = out_len_ff;
   assign rsp_peer_length  = out_peer_ff;

endmodule
